/* hw/rtl/lpm_pkg.sv */
package lpm_pkg;

  localparam int ADDR_BITS          = 32;
  localparam int LEN_W              = 6;
  localparam int IFC_W              = 3;
  localparam int TTL_W              = 8;
  localparam int ROUTE_ENTRIES_DEF  = 16;
  localparam int INTERFACES_DEF     = 8;

  typedef enum logic [2:0] {
    ST_FORWARD  = 3'd0,
    ST_TTL_DROP = 3'd1,
    ST_NO_ROUTE = 3'd2,
    ST_ADDED    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic {
    REQ_ADD   = 1'b0,
    REQ_ROUTE = 1'b1
  } req_t;

  // Route entry as written into one cell.
  typedef struct packed {
    logic [ADDR_BITS-1:0] prefix;
    logic [LEN_W-1:0]     len;
    logic [ADDR_BITS-1:0] mask;
    logic                 has_hop;
    logic [ADDR_BITS-1:0] hop;
    logic [IFC_W-1:0]     ifc;
  } entry_t;

  // Lookup token handed from cell to cell, carrying the best match so far.
  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] dst;
    logic [TTL_W-1:0]     ttl;
    logic                 found;
    logic [LEN_W-1:0]     best_len;
    logic [IFC_W-1:0]     ifc;
    logic [ADDR_BITS-1:0] hop;
  } token_t;

  // Mask with the leading len bits set; len is already saturated to 32.
  function automatic logic [ADDR_BITS-1:0] len_mask(input logic [LEN_W-1:0] len);
    return ~({ADDR_BITS{1'b1}} >> len);
  endfunction

  // Wraps a 3-bit interface number into 0..n-1 by repeated subtraction.
  function automatic logic [IFC_W-1:0] ifc_wrap(input logic [IFC_W-1:0] v, input int n);
    logic [IFC_W-1:0] r;
    r = v;
    for (int k = 0; k < (1 << IFC_W); k++) begin
      if (int'(r) >= n) begin
        r = r - IFC_W'(n);
      end
    end
    return r;
  endfunction

endpackage

/* hw/rtl/lpm_cell.sv */
// One route entry plus one stage of the lookup chain.
module lpm_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  lpm_pkg::entry_t wr_entry,
  input  logic            active,
  input  lpm_pkg::token_t tok_in,
  output lpm_pkg::token_t tok_out
);

  lpm_pkg::entry_t entry;
  logic            hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry <= wr_entry;
    end
  end

  assign hit = active && tok_in.valid
            && (((tok_in.dst ^ entry.prefix) & entry.mask) == '0)
            && (entry.len >= tok_in.best_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.dst <= tok_in.dst;
    tok_out.ttl <= tok_in.ttl;
    if (hit) begin
      tok_out.found    <= 1'b1;
      tok_out.best_len <= entry.len;
      tok_out.ifc      <= entry.ifc;
      tok_out.hop      <= entry.has_hop ? entry.hop : tok_in.dst;
    end else begin
      tok_out.found    <= tok_in.found;
      tok_out.best_len <= tok_in.best_len;
      tok_out.ifc      <= tok_in.ifc;
      tok_out.hop      <= tok_in.hop;
    end
  end

endmodule

/* hw/rtl/longest_prefix_match_router_core.sv */
// IPv4 longest-prefix-match router core. Each route lives in its own cell of a chain of
// ROUTE_ENTRIES cells. An add request writes the next free cell and its result (route added,
// or table full) is ready in the cycle after acceptance. A route request whose TTL is zero or
// one is answered in the same way. Any other route request launches a lookup token into the
// head of the chain; the token moves one cell per cycle, each cell comparing the destination
// under its own mask and keeping the longest (and, on a tie, the later) match, and the
// result passes from the last cell into the output register. That walk along
// the chain sets the lookup rate: the core takes one request at a time and accepts the next
// request once the lookup has left the chain and the output register is free or being read.
module longest_prefix_match_router_core #(
  parameter int ROUTE_ENTRIES = lpm_pkg::ROUTE_ENTRIES_DEF,
  parameter int INTERFACES    = lpm_pkg::INTERFACES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // From bit 0: add_prefix[31:0], prefix_len[37:32], has_next_hop[38],
  // next_hop_ip[70:39], interface_index[73:71], dst_address[105:74],
  // time_to_live[113:106], zero padding[119:114].
  input  logic [119:0] s_tdata,
  // req_type: 0 adds a route, 1 routes a datagram.
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // From bit 0: status[2:0], out_interface[5:3], next_hop_address[37:6],
  // new_ttl[45:38], zero padding[47:46].
  output logic [47:0]  m_tdata
);

  localparam int CNT_W = $clog2(ROUTE_ENTRIES + 1);

  // Request fields, unpacked from the input bus.
  logic [31:0] add_prefix;
  logic [5:0]  prefix_len;
  logic        has_next_hop;
  logic [31:0] next_hop_ip;
  logic [2:0]  interface_index;
  logic [31:0] dst_address;
  logic [7:0]  time_to_live;

  assign add_prefix      = s_tdata[31:0];
  assign prefix_len      = s_tdata[37:32];
  assign has_next_hop    = s_tdata[38];
  assign next_hop_ip     = s_tdata[70:39];
  assign interface_index = s_tdata[73:71];
  assign dst_address     = s_tdata[105:74];
  assign time_to_live    = s_tdata[113:106];

  // Control state.
  logic [CNT_W-1:0] route_count;
  logic             busy;

  // Result register.
  lpm_pkg::status_t res_status;
  logic [2:0]       res_ifc;
  logic [31:0]      res_hop;
  logic [7:0]       res_ttl;

  logic accept;
  logic is_add;
  logic table_full;
  logic add_ok;
  logic ttl_drop;
  logic launch;

  lpm_pkg::entry_t  wr_entry;
  lpm_pkg::token_t  tok [ROUTE_ENTRIES+1];
  lpm_pkg::token_t  tok_exit;
  logic [5:0]       sat_len;

  // The core holds one request at a time; a new one is taken only out of reset, with the
  // output slot free, or being emptied in this very cycle.
  assign s_tready   = !rst && !busy && (!m_tvalid || m_tready);
  assign accept     = s_tvalid && s_tready;
  assign is_add     = (s_tuser == lpm_pkg::REQ_ADD);
  assign table_full = (route_count >= CNT_W'(ROUTE_ENTRIES));
  assign add_ok     = accept && is_add && !table_full;
  assign ttl_drop   = (time_to_live <= 8'd1);
  assign launch     = accept && !is_add && !ttl_drop;

  // Prefix lengths above 32 are stored as 32; the mask is worked out once, at write time.
  assign sat_len = (prefix_len > 6'(lpm_pkg::ADDR_BITS)) ? 6'(lpm_pkg::ADDR_BITS) : prefix_len;

  assign wr_entry.prefix  = add_prefix;
  assign wr_entry.len     = sat_len;
  assign wr_entry.mask    = lpm_pkg::len_mask(sat_len);
  assign wr_entry.has_hop = has_next_hop;
  assign wr_entry.hop     = next_hop_ip;
  assign wr_entry.ifc     = lpm_pkg::ifc_wrap(interface_index, INTERFACES);

  // The head of the chain sees a fresh token only in the launch cycle.
  assign tok[0].valid    = launch;
  assign tok[0].dst      = dst_address;
  assign tok[0].ttl      = time_to_live - 8'd1;
  assign tok[0].found    = 1'b0;
  assign tok[0].best_len = '0;
  assign tok[0].ifc      = '0;
  assign tok[0].hop      = '0;

  // One cell per route. A cell takes part in a lookup only once its entry has been
  // written, which is exactly when its position lies below the route count.
  for (genvar i = 0; i < ROUTE_ENTRIES; i++) begin : g_cell
    lpm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (add_ok && (route_count == CNT_W'(i))),
      .wr_entry (wr_entry),
      .active   (route_count > CNT_W'(i)),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

  assign tok_exit = tok[ROUTE_ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      route_count <= '0;
      busy        <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (add_ok) begin
        route_count <= route_count + CNT_W'(1);
      end
      if (launch) begin
        busy <= 1'b1;
      end
      if (tok_exit.valid) begin
        busy     <= 1'b0;
        m_tvalid <= 1'b1;
      end
      if (accept && !launch) begin
        m_tvalid <= 1'b1;
      end
    end

    // Result payload; fields other than the status are zero unless the datagram is
    // forwarded.
    if (accept && !launch) begin
      res_ifc <= '0;
      res_hop <= '0;
      res_ttl <= '0;
      if (is_add) begin
        res_status <= table_full ? lpm_pkg::ST_FULL : lpm_pkg::ST_ADDED;
      end else begin
        res_status <= lpm_pkg::ST_TTL_DROP;
      end
    end else if (tok_exit.valid) begin
      if (tok_exit.found) begin
        res_status <= lpm_pkg::ST_FORWARD;
        res_ifc    <= tok_exit.ifc;
        res_hop    <= tok_exit.hop;
        res_ttl    <= tok_exit.ttl;
      end else begin
        res_status <= lpm_pkg::ST_NO_ROUTE;
        res_ifc    <= '0;
        res_hop    <= '0;
        res_ttl    <= '0;
      end
    end
  end

  assign m_tdata = {2'b00, res_ttl, res_hop, res_ifc, res_status};

`ifndef SYNTHESIS
  // No request may be taken while a lookup is still walking the chain.
  assert property (@(posedge clk) disable iff (rst) busy |-> !s_tready)
    else $error("request accepted during a lookup");

  // A token only leaves the chain while a lookup is outstanding.
  assert property (@(posedge clk) disable iff (rst) tok_exit.valid |-> busy)
    else $error("lookup result without an outstanding lookup");

  // A lookup result must land in an empty output register.
  assert property (@(posedge clk) disable iff (rst) tok_exit.valid |-> !m_tvalid)
    else $error("lookup result would overwrite a pending result");

  // The route count never passes the table size.
  assert property (@(posedge clk) disable iff (rst) route_count <= CNT_W'(ROUTE_ENTRIES))
    else $error("route count beyond table size");

  // The route count only ever grows by one, and only on an accepted add.
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (route_count != $past(route_count)))
      |-> (route_count == $past(route_count) + CNT_W'(1)) && $past(add_ok))
    else $error("route count changed without an add");
`endif

endmodule

/* verif/tb_longest_prefix_match_router_core.sv */
module tb_longest_prefix_match_router_core;

  localparam int NUM_ROUTES      = lpm_pkg::ROUTE_ENTRIES_DEF;
  localparam int NUM_IFC         = lpm_pkg::INTERFACES_DEF;
  localparam int RANDOM_REQUESTS = 950;
  localparam int DRAIN_AT        = 400;
  localparam int HOLDOFF_AT      = 60;
  localparam int HOLDOFF_CYCLES  = 400;
  localparam int CYCLE_LIMIT     = 500000;

  typedef struct {
    lpm_pkg::req_t                 kind;
    logic [lpm_pkg::ADDR_BITS-1:0] prefix;
    logic [lpm_pkg::LEN_W-1:0]     len;
    logic                          has_hop;
    logic [lpm_pkg::ADDR_BITS-1:0] hop;
    logic [lpm_pkg::IFC_W-1:0]     ifc;
    logic [lpm_pkg::ADDR_BITS-1:0] dst;
    logic [lpm_pkg::TTL_W-1:0]     ttl;
    bit                            drain_first;
  } request_t;

  typedef struct {
    logic [lpm_pkg::ADDR_BITS-1:0] prefix;
    logic [lpm_pkg::LEN_W-1:0]     len;
    logic                          has_hop;
    logic [lpm_pkg::ADDR_BITS-1:0] hop;
    logic [lpm_pkg::IFC_W-1:0]     ifc;
  } route_t;

  typedef struct {
    lpm_pkg::status_t              status;
    logic [lpm_pkg::IFC_W-1:0]     ifc;
    logic [lpm_pkg::ADDR_BITS-1:0] hop;
    logic [lpm_pkg::TTL_W-1:0]     ttl;
  } verdict_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [119:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [47:0]  m_tdata;

  request_t    request_q[$];
  verdict_t    verdict_q[$];
  route_t      fib[NUM_ROUTES];
  int unsigned fib_count = 0;
  int unsigned total_requests = 0;
  int unsigned sent_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned errors = 0;
  int unsigned status_tally[5] = '{default: 0};
  verdict_t    seen_want;

  longest_prefix_match_router_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic bit chance(input int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Leading len bits set; len is taken as already limited to 32.
  function automatic logic [lpm_pkg::ADDR_BITS-1:0] prefix_mask(
      input logic [lpm_pkg::LEN_W-1:0] len);
    if (len == 0) return '0;
    if (len >= lpm_pkg::ADDR_BITS) return '1;
    return {lpm_pkg::ADDR_BITS{1'b1}} << (lpm_pkg::ADDR_BITS - int'(len));
  endfunction

  // Updates the shadow routing table and queues the result that the request must produce.
  task automatic resolve_request(input request_t r);
    verdict_t                  v;
    bit                        found;
    logic [lpm_pkg::LEN_W-1:0] best_len;
    int                        best;
    v = '{status: lpm_pkg::ST_FORWARD, ifc: '0, hop: '0, ttl: '0};
    found = 1'b0;
    best_len = '0;
    best = 0;
    if (r.kind == lpm_pkg::REQ_ADD) begin
      if (fib_count >= NUM_ROUTES) begin
        v.status = lpm_pkg::ST_FULL;
      end else begin
        fib[fib_count] = '{prefix: r.prefix,
                           len: (r.len > lpm_pkg::ADDR_BITS) ?
                                lpm_pkg::LEN_W'(lpm_pkg::ADDR_BITS) : r.len,
                           has_hop: r.has_hop, hop: r.hop,
                           ifc: lpm_pkg::IFC_W'(int'(r.ifc) % NUM_IFC)};
        fib_count++;
        v.status = lpm_pkg::ST_ADDED;
      end
    end else if (r.ttl <= 1) begin
      v.status = lpm_pkg::ST_TTL_DROP;
    end else begin
      // Later entries win ties, hence the greater-or-equal comparison.
      for (int i = 0; i < fib_count; i++) begin
        if (((r.dst ^ fib[i].prefix) & prefix_mask(fib[i].len)) == '0 &&
            fib[i].len >= best_len) begin
          found = 1'b1;
          best_len = fib[i].len;
          best = i;
        end
      end
      if (!found) begin
        v.status = lpm_pkg::ST_NO_ROUTE;
      end else begin
        v.ifc = fib[best].ifc;
        v.hop = fib[best].has_hop ? fib[best].hop : r.dst;
        v.ttl = r.ttl - 1'b1;
      end
    end
    verdict_q.insert(verdict_q.size(), v);
  endtask

  task automatic queue_request(input lpm_pkg::req_t kind, input logic [31:0] prefix,
                               input logic [5:0] len, input logic has_hop,
                               input logic [31:0] hop, input logic [2:0] ifc,
                               input logic [31:0] dst, input logic [7:0] ttl,
                               input bit drain_first);
    request_q.insert(request_q.size(),
                     '{kind: kind, prefix: prefix, len: len, has_hop: has_hop, hop: hop,
                       ifc: ifc, dst: dst, ttl: ttl, drain_first: drain_first});
  endtask

  // Driver: the head of the request queue is offered until it is accepted, then popped.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        resolve_request(request_q[0]);
        request_q.pop_front();
        sent_count <= sent_count + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (request_q.size() != 0 &&
            !(request_q[0].drain_first && verdict_q.size() != 0) &&
            !chance(sent_count < total_requests / 3     ? 30 :
                    sent_count < 2 * total_requests / 3 ? 81 : 0)) begin
          s_tvalid <= 1'b1;
          s_tuser  <= request_q[0].kind;
          s_tdata  <= {6'b0, request_q[0].ttl, request_q[0].dst, request_q[0].ifc,
                       request_q[0].hop, request_q[0].has_hop, request_q[0].len,
                       request_q[0].prefix};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness, with one long hold-off early on so that the core backs up.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (!hold_done && sent_count >= HOLDOFF_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLDOFF_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= !chance(sent_count < total_requests / 3     ? 81 :
                          sent_count < 2 * total_requests / 3 ? 30 : 0);
    end
  end

  // Monitor: every accepted result is checked against the oldest outstanding verdict.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        $error("result with no request outstanding: m_tdata=%h", m_tdata);
        errors++;
      end else begin
        seen_want = verdict_q.pop_front();
        status_tally[int'(seen_want.status)]++;
        if (m_tdata[2:0] !== seen_want.status) begin
          $error("status: expected %0d, actual %0d", seen_want.status, m_tdata[2:0]);
          errors++;
        end
        if (m_tdata[5:3] !== seen_want.ifc) begin
          $error("out_interface: expected %0d, actual %0d", seen_want.ifc, m_tdata[5:3]);
          errors++;
        end
        if (m_tdata[37:6] !== seen_want.hop) begin
          $error("next_hop_address: expected %h, actual %h", seen_want.hop, m_tdata[37:6]);
          errors++;
        end
        if (m_tdata[45:38] !== seen_want.ttl) begin
          $error("new_ttl: expected %0d, actual %0d", seen_want.ttl, m_tdata[45:38]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL longest_prefix_match_router_core");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] gen_prefix[$];
    logic [5:0]  gen_len[$];
    logic [31:0] msk;
    logic [31:0] p;
    logic [31:0] d;
    logic [5:0]  l;
    logic [7:0]  t;
    int          pick;
    int          k;

    // Directed part: empty table, TTL boundary values, saturated lengths, default route, tie on length.
    queue_request(lpm_pkg::REQ_ROUTE, 32'h0, 6'd0, 1'b0, 32'h0, 3'd0, 32'h0A01_0203, 8'd64,
                  1'b0);
    queue_request(lpm_pkg::REQ_ROUTE, 32'h0, 6'd0, 1'b0, 32'h0, 3'd0, 32'h0A01_0203, 8'd0,
                  1'b0);
    queue_request(lpm_pkg::REQ_ROUTE, 32'h0, 6'd0, 1'b0, 32'h0, 3'd0, 32'h0A01_0203, 8'd1,
                  1'b0);
    queue_request(lpm_pkg::REQ_ADD, 32'h0A00_0000, 6'd8, 1'b1, 32'hC0A8_0101, 3'd1, 32'h0,
                  8'd0, 1'b0);
    queue_request(lpm_pkg::REQ_ADD, 32'h0A01_0000, 6'd16, 1'b0, 32'h0, 3'd2, 32'h0, 8'd0,
                  1'b0);
    queue_request(lpm_pkg::REQ_ROUTE, 32'h0, 6'd0, 1'b0, 32'h0, 3'd0, 32'h0A01_0203, 8'd2,
                  1'b0);
    queue_request(lpm_pkg::REQ_ROUTE, 32'h0, 6'd0, 1'b0, 32'h0, 3'd0, 32'h0A02_0001, 8'd255,
                  1'b0);
    queue_request(lpm_pkg::REQ_ROUTE, 32'h0, 6'd0, 1'b0, 32'h0, 3'd0, 32'h0B00_0001, 8'd9,
                  1'b0);
    queue_request(lpm_pkg::REQ_ADD, 32'hFFFF_FFFF, 6'd63, 1'b1, 32'hFFFF_FFFF, 3'd7, 32'h0,
                  8'd0, 1'b0);
    queue_request(lpm_pkg::REQ_ROUTE, 32'h0, 6'd0, 1'b0, 32'h0, 3'd0, 32'hFFFF_FFFF, 8'd255,
                  1'b0);
    queue_request(lpm_pkg::REQ_ROUTE, 32'h0, 6'd0, 1'b0, 32'h0, 3'd0, 32'hFFFF_FFFE, 8'd7,
                  1'b0);
    queue_request(lpm_pkg::REQ_ADD, 32'hDEAD_BEEF, 6'd0, 1'b1, 32'h0, 3'd0, 32'h0, 8'd0,
                  1'b0);
    queue_request(lpm_pkg::REQ_ROUTE, 32'h0, 6'd0, 1'b0, 32'h0, 3'd0, 32'hFFFF_FFFE, 8'd7,
                  1'b0);
    queue_request(lpm_pkg::REQ_ADD, 32'h0A01_0000, 6'd16, 1'b1, 32'h0A0A_0A0A, 3'd5, 32'h0,
                  8'd0, 1'b0);
    queue_request(lpm_pkg::REQ_ROUTE, 32'h0, 6'd0, 1'b0, 32'h0, 3'd0, 32'h0A01_0909, 8'd100,
                  1'b0);
    queue_request(lpm_pkg::REQ_ADD, 32'h1234_5678, 6'd33, 1'b0, 32'h0, 3'd4, 32'h0, 8'd0,
                  1'b0);
    queue_request(lpm_pkg::REQ_ROUTE, 32'h0, 6'd0, 1'b0, 32'h0, 3'd0, 32'h1234_5678, 8'd3,
                  1'b0);
    queue_request(lpm_pkg::REQ_ROUTE, 32'h0, 6'd0, 1'b0, 32'h0, 3'd0, 32'h1234_5679, 8'd3,
                  1'b0);
    queue_request(lpm_pkg::REQ_ROUTE, 32'h0, 6'd0, 1'b0, 32'h0, 3'd0, 32'h0A01_0000, 8'd0,
                  1'b0);
    gen_prefix = '{32'h0A00_0000, 32'h0A01_0000, 32'hFFFF_FFFF, 32'hDEAD_BEEF,
                   32'h0A01_0000, 32'h1234_5678};
    gen_len    = '{6'd8, 6'd16, 6'd32, 6'd0, 6'd16, 6'd32};

    // Random part: mostly lookups aimed at stored prefixes, some near misses and strays,
    // and occasional adds that first fill the table and later bounce off it.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if ($urandom_range(0, 13) == 0) begin
        l = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63)) : 6'($urandom_range(0, 32));
        p = $urandom;
        if ($urandom_range(0, 1) == 1) begin
          // Nest the new route inside an existing one.
          pick = $urandom_range(0, gen_prefix.size() - 1);
          msk = prefix_mask(gen_len[pick]);
          p = (gen_prefix[pick] & msk) | (p & ~msk);
        end
        if (gen_prefix.size() < NUM_ROUTES) begin
          gen_prefix.insert(gen_prefix.size(), p);
          gen_len.insert(gen_len.size(), (l > 32) ? 6'd32 : l);
        end
        queue_request(lpm_pkg::REQ_ADD, p, l, 1'($urandom_range(0, 1)), $urandom,
                      3'($urandom_range(0, 7)), $urandom, 8'($urandom_range(0, 255)),
                      n == DRAIN_AT);
      end else begin
        d = $urandom;
        k = $urandom_range(0, 99);
        if (k < 75) begin
          pick = $urandom_range(0, gen_prefix.size() - 1);
          msk = prefix_mask(gen_len[pick]);
          d = (gen_prefix[pick] & msk) | (d & ~msk);
          // Flip the last prefix bit so that this route just misses.
          if (k >= 60 && gen_len[pick] != 0) begin
            d[32 - gen_len[pick]] = ~d[32 - gen_len[pick]];
          end
        end
        t = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(2, 255));
        queue_request(lpm_pkg::REQ_ROUTE, $urandom, 6'($urandom_range(0, 63)),
                      1'($urandom_range(0, 1)), $urandom, 3'($urandom_range(0, 7)), d, t,
                      n == DRAIN_AT);
      end
    end
    total_requests = request_q.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (request_q.size() != 0) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    // A lookup walks every table entry, so allow a full walk for stray results.
    repeat (NUM_ROUTES + 8) @(posedge clk);
    if (verdict_q.size() != 0) begin
      $error("%0d results never arrived", verdict_q.size());
      errors++;
    end

    $display("Covered %0d requests: %0d forwarded, %0d dropped on TTL, %0d without a route,",
             total_requests, status_tally[lpm_pkg::ST_FORWARD],
             status_tally[lpm_pkg::ST_TTL_DROP], status_tally[lpm_pkg::ST_NO_ROUTE]);
    $display("%0d routes stored and %0d refused on a full table, under three idling mixes.",
             status_tally[lpm_pkg::ST_ADDED], status_tally[lpm_pkg::ST_FULL]);
    if (errors == 0) begin
      $display("PASS longest_prefix_match_router_core");
    end else begin
      $display("FAIL longest_prefix_match_router_core");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/lpm_pkg.sv
hw/rtl/lpm_cell.sv
hw/rtl/longest_prefix_match_router_core.sv
verif/tb_longest_prefix_match_router_core.sv
